// ===== src/psa_pkg.sv =====
// shared types and constants of the process slot allocator
package psa_pkg;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_LOOKUP  = 2'd2,
		OP_SET_CUR = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_BAD    = 2'd2;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPW    = $clog2(QDEPTH);
	localparam int unsigned QCW    = $clog2(QDEPTH + 1);

	localparam int unsigned CNT_W = 21;

	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] parent_pid;
		logic [31:0] lookup_id;
		logic        check_perm;
		logic [9:0]  slot_in;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  slot_out;
		logic        slot_valid;
		logic [31:0] id_out;
	} rsp_beat_t;

	typedef struct packed {
		op_t         kind;
		logic [31:0] parent_pid;
		logic [31:0] lookup_id;
		logic        lookup_cur;
		logic        check_perm;
		logic [9:0]  slot_in;
	} cmd_t;

	typedef struct packed {
		logic        used;
		logic [31:0] id;
	} slot_ent_t;

endpackage

// ===== src/process_slot_allocator_top.sv =====
// top level of the process slot allocator
//
// usage:
//   request channel (req_valid / req_stall / req) carries one command per beat:
//   allocate, release a slot, look up an id, or make a slot current
//   response channel (rsp_valid / rsp_stall / rsp) returns exactly one beat per
//   request, in request order, with status, slot and id
//   a beat moves on a rising edge with valid high and stall low
// timing:
//   a lone request passes the command queue, the issue state and the execute
//   state before its response shows; commands execute one at a time: each reads
//   the slot memories through their registered read port, then writes them back
//   a two-entry command queue keeps taking requests while a response waits
// reset (arst_n low, asynchronous):
//   every slot free with slot 0 on top of the stack, no current slot, id
//   counter zero; no memory sweep, the block takes requests right away
// receiver stall:
//   the response register holds its beat; execution pauses, and req_stall
//   rises once the command queue has filled
module process_slot_allocator_top
	import psa_pkg::*;
#(
	parameter int unsigned LOG_SLOTS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	// decoded command handoff between intake and execution
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// intake: decode and queue requests
	psa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd)
	);

	// execution: slot table, free stack and response register
	psa_back #(.LOG_SLOTS(LOG_SLOTS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== src/psa_ram.sv =====
// generic single write port ram with registered read
module psa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== src/psa_front.sv =====
// request intake: decode beats and hold them in a short command queue
module psa_front
	import psa_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_beat_t req,
	output logic      cmd_valid,
	input  logic      cmd_pop,
	output cmd_t      cmd
);

	cmd_t           ent_q [QDEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] cnt_q;
	logic           push;
	cmd_t           dec;

	assign req_stall = (cnt_q == QCW'(QDEPTH));
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = ent_q[rd_ptr_q];

	// classify the request
	always_comb begin
		dec.kind       = op_t'(req.op);
		dec.parent_pid = req.parent_pid;
		dec.lookup_id  = req.lookup_id;
		dec.lookup_cur = (req.lookup_id == '0);
		dec.check_perm = req.check_perm;
		dec.slot_in    = req.slot_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPW'(1);
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + QPW'(1);
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= dec;
		end
	end

endmodule

// ===== src/psa_back.sv =====
// command execution: slot memories, free stack, current slot and response register
module psa_back
	import psa_pkg::*;
#(
	parameter int unsigned LOG_SLOTS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_pop,
	input  cmd_t      cmd,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_beat_t rsp
);

	localparam int unsigned SW     = LOG_SLOTS;
	localparam int unsigned NSLOTS = 1 << LOG_SLOTS;
	localparam int unsigned EW     = $bits(slot_ent_t);

	typedef enum logic [1:0] {
		S_ISSUE = 2'b01,
		S_EXEC  = 2'b10
	} bstate_t;

	bstate_t         state_q;
	bstate_t         state_d;
	cmd_t            cmd_q;
	logic [SW:0]     fc_q;
	logic [SW:0]     mark_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]   cur_slot_q;
	logic            cur_valid_q;
	logic [31:0]     cur_id_q;
	logic            rsp_valid_q;
	rsp_beat_t       rsp_q;

	logic [SW:0]     fc_d;
	logic [SW:0]     mark_d;
	logic [CNT_W-1:0] cnt_d;
	logic [SW-1:0]   cur_slot_d;
	logic            cur_valid_d;
	logic [31:0]     cur_id_d;
	rsp_beat_t       res;

	logic            go;
	logic [SW:0]     fc_dec;
	logic [SW-1:0]   ent_rd_addr;
	logic [SW-1:0]   par_rd_addr;
	logic [SW-1:0]   stk_rd_addr;
	logic [EW-1:0]   ent_rd_raw;
	slot_ent_t       ent_rd;
	logic [31:0]     par_rd;
	logic [SW-1:0]   stk_rd;

	logic            ent_we;
	logic [SW-1:0]   ent_wa;
	slot_ent_t       ent_wd;
	logic            par_we;
	logic            stk_we;

	logic [SW-1:0]   x_slot;
	logic [SW-1:0]   x_lid;
	logic [SW-1:0]   x_ent;
	logic [SW:0]     touched_end;
	logic            ent_used;
	logic            pop_fresh;
	logic [SW:0]     fresh_slot;
	logic [SW-1:0]   pop_slot;
	logic [CNT_W-1:0] cnt_inc;
	logic [31:0]     new_id;

	// issue side: table read addresses come from the queue head, the stack read address from the free count
	assign go          = (state_q == S_ISSUE) && cmd_valid && (!rsp_valid_q || !rsp_stall);
	assign cmd_pop     = go;
	assign fc_dec      = fc_q - (SW+1)'(1);
	assign ent_rd_addr = (cmd.kind == OP_LOOKUP) ? SW'(cmd.lookup_id) : SW'(cmd.slot_in);
	assign par_rd_addr = SW'(cmd.lookup_id);
	assign stk_rd_addr = fc_dec[SW-1:0];

	psa_ram #(.WIDTH(EW), .DEPTH(NSLOTS)) u_ent_ram (
		.clk     (clk),
		.wr_en   (ent_we),
		.wr_addr (ent_wa),
		.wr_data (ent_wd),
		.rd_addr (ent_rd_addr),
		.rd_data (ent_rd_raw)
	);

	psa_ram #(.WIDTH(32), .DEPTH(NSLOTS)) u_par_ram (
		.clk     (clk),
		.wr_en   (par_we),
		.wr_addr (pop_slot),
		.wr_data (cmd_q.parent_pid),
		.rd_addr (par_rd_addr),
		.rd_data (par_rd)
	);

	psa_ram #(.WIDTH(SW), .DEPTH(NSLOTS)) u_stk_ram (
		.clk     (clk),
		.wr_en   (stk_we),
		.wr_addr (fc_q[SW-1:0]),
		.wr_data (x_slot),
		.rd_addr (stk_rd_addr),
		.rd_data (stk_rd)
	);

	assign ent_rd = slot_ent_t'(ent_rd_raw);

	// slots at or above the touched bound were never handed out since reset
	assign x_slot      = SW'(cmd_q.slot_in);
	assign x_lid       = SW'(cmd_q.lookup_id);
	assign x_ent       = (cmd_q.kind == OP_LOOKUP) ? x_lid : x_slot;
	assign touched_end = (SW+1)'(NSLOTS) - mark_q;
	assign ent_used    = ({1'b0, x_ent} < touched_end) && ent_rd.used;

	// a pop at the low mark would read a stack entry never written since reset
	assign pop_fresh  = (fc_q == mark_q);
	assign fresh_slot = (SW+1)'(NSLOTS) - fc_q;
	assign pop_slot   = pop_fresh ? fresh_slot[SW-1:0] : stk_rd;
	assign cnt_inc    = cnt_q + CNT_W'(1);
	assign new_id     = 32'(64'(cnt_inc) << (SW + 1)) | 32'(pop_slot);

	always_comb begin
		res         = '0;
		ent_we      = 1'b0;
		ent_wa      = x_slot;
		ent_wd.used = 1'b0;
		ent_wd.id   = ent_rd.id;
		par_we      = 1'b0;
		stk_we      = 1'b0;
		fc_d        = fc_q;
		mark_d      = mark_q;
		cnt_d       = cnt_q;
		cur_slot_d  = cur_slot_q;
		cur_valid_d = cur_valid_q;
		cur_id_d    = cur_id_q;
		if (state_q == S_EXEC) begin
			unique case (cmd_q.kind)
				OP_ALLOC: begin
					if (fc_q == '0) begin
						res.status = ST_NOFREE;
					end else begin
						ent_we      = 1'b1;
						ent_wa      = pop_slot;
						ent_wd.used = 1'b1;
						ent_wd.id   = new_id;
						par_we      = 1'b1;
						fc_d        = fc_dec;
						if (pop_fresh) begin
							mark_d = fc_dec;
						end
						cnt_d = cnt_inc;
						if (pop_slot == cur_slot_q) begin
							cur_id_d = new_id;
						end
						res.status     = ST_OK;
						res.slot_out   = 10'(pop_slot);
						res.slot_valid = 1'b1;
						res.id_out     = new_id;
					end
				end
				OP_RELEASE: begin
					if (!ent_used || fc_q[SW]) begin
						res.status = ST_BAD;
					end else begin
						ent_we = 1'b1;
						stk_we = 1'b1;
						fc_d   = fc_q + (SW+1)'(1);
						if (cur_valid_q && (cur_slot_q == x_slot)) begin
							cur_valid_d = 1'b0;
							cur_slot_d  = '0;
						end
						res.status     = ST_OK;
						res.slot_out   = 10'(x_slot);
						res.slot_valid = 1'b1;
						res.id_out     = ent_rd.id;
					end
				end
				OP_SET_CUR: begin
					cur_slot_d     = x_slot;
					cur_valid_d    = 1'b1;
					cur_id_d       = ent_rd.id;
					res.status     = ST_OK;
					res.slot_out   = 10'(x_slot);
					res.slot_valid = 1'b1;
				end
				OP_LOOKUP: begin
					if (cmd_q.lookup_cur) begin
						res.status = ST_OK;
						if (cur_valid_q) begin
							res.slot_out   = 10'(cur_slot_q);
							res.slot_valid = 1'b1;
							res.id_out     = cur_id_q;
						end
					end else if (!ent_used || (ent_rd.id != cmd_q.lookup_id)) begin
						res.status = ST_BAD;
					end else if (cmd_q.check_perm && (!cur_valid_q ||
							((x_lid != cur_slot_q) && (par_rd != cur_id_q)))) begin
						res.status = ST_BAD;
					end else begin
						res.status     = ST_OK;
						res.slot_out   = 10'(x_lid);
						res.slot_valid = 1'b1;
						res.id_out     = ent_rd.id;
					end
				end
				default: begin
					res.status = ST_BAD;
				end
			endcase
		end
	end

	always_comb begin
		unique case (state_q)
			S_ISSUE: state_d = go ? S_EXEC : S_ISSUE;
			S_EXEC:  state_d = S_ISSUE;
			default: state_d = S_ISSUE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_ISSUE;
			fc_q        <= (SW+1)'(NSLOTS);
			mark_q      <= (SW+1)'(NSLOTS);
			cnt_q       <= '0;
			cur_slot_q  <= '0;
			cur_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fc_q        <= fc_d;
			mark_q      <= mark_d;
			cnt_q       <= cnt_d;
			cur_slot_q  <= cur_slot_d;
			cur_valid_q <= cur_valid_d;
			if (state_q == S_EXEC) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			cmd_q <= cmd;
		end
		if (state_q == S_EXEC) begin
			rsp_q <= res;
		end
		cur_id_q <= cur_id_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef NO_ASSERTIONS
	a_mark_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(mark_q <= fc_q) && (fc_q <= (SW+1)'(NSLOTS)))
		else $error("free count outside low mark and table size");

	a_exec_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> !rsp_valid_q)
		else $error("result produced while response register occupied");

	a_alloc_pops: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EXEC) && (cmd_q.kind == OP_ALLOC) && (fc_q != '0))
		|=> (fc_q == $past(fc_q) - (SW+1)'(1)))
		else $error("allocation did not pop the free stack");

	a_release_clears_cur: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_EXEC) && (cmd_q.kind == OP_RELEASE) && (res.status == ST_OK) &&
		cur_valid_q && (cur_slot_q == x_slot)) |=> !cur_valid_q)
		else $error("release of current slot left it current");
`endif

endmodule

// ===== verif/tb_process_slot_allocator_top.sv =====
// testbench for the process slot allocator: directed steps, then random traffic against a shadow slot table
`timescale 1ns / 1ps

module tb_process_slot_allocator_top;
	import psa_pkg::*;

	localparam int LOG = 10;
	localparam int NSLOT = 1 << LOG;
	localparam int N_RANDOM = 1750;

	// one row of the directed steps; want is used only where fixed is set
	typedef struct {
		req_beat_t beat;
		bit        fixed;
		rsp_beat_t want;
	} step_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_beat_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_beat_t rsp;

	// shadow copy of the slot table
	logic [9:0]       free_stk [NSLOT];
	int               free_cnt;
	bit               busy     [NSLOT];
	bit               written  [NSLOT];
	logic [31:0]      slot_pid [NSLOT];
	logic [31:0]      slot_par [NSLOT];
	logic [CNT_W-1:0] id_ctr;
	logic [9:0]       cur_slot;
	bit               cur_ok;

	// responses still owed by the block, oldest first
	rsp_beat_t rsp_due[$];
	step_t     steps[$];
	int        mismatches = 0;
	int        burst_left = 0;

	process_slot_allocator_top #(.LOG_SLOTS(LOG)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always #6 clk = ~clk;

	// runs one command on the shadow table and returns the response it owes
	function automatic rsp_beat_t run_slot_op(input req_beat_t b);
		rsp_beat_t r;
		logic [9:0] s;
		logic [9:0] e;
		r = '0;
		s = b.slot_in;
		case (b.op)
			OP_ALLOC: begin
				if (free_cnt == 0) begin
					r.status = ST_NOFREE;
				end else begin
					free_cnt--;
					e = free_stk[free_cnt];
					id_ctr = id_ctr + 1'b1;
					busy[e] = 1'b1;
					written[e] = 1'b1;
					slot_par[e] = b.parent_pid;
					slot_pid[e] = {id_ctr, 1'b0, e};
					r = '{ST_OK, e, 1'b1, slot_pid[e]};
				end
			end
			OP_RELEASE: begin
				if (!busy[s]) begin
					r.status = ST_BAD;
				end else begin
					busy[s] = 1'b0;
					free_stk[free_cnt] = s;
					free_cnt++;
					// releasing the current slot drops it
					if (cur_ok && cur_slot == s) begin
						cur_ok = 1'b0;
						cur_slot = '0;
					end
					r = '{ST_OK, s, 1'b1, slot_pid[s]};
				end
			end
			OP_SET_CUR: begin
				cur_slot = s;
				cur_ok = 1'b1;
				r = '{ST_OK, s, 1'b1, 32'd0};
			end
			default: begin
				e = b.lookup_id[9:0];
				if (b.lookup_id == '0) begin
					if (cur_ok)
						r = '{ST_OK, cur_slot, 1'b1, slot_pid[cur_slot]};
				end else if (!busy[e] || slot_pid[e] != b.lookup_id) begin
					r.status = ST_BAD;
				end else if (b.check_perm && (!cur_ok ||
						(e != cur_slot && slot_par[e] != slot_pid[cur_slot]))) begin
					r.status = ST_BAD;
				end else begin
					r = '{ST_OK, e, 1'b1, slot_pid[e]};
				end
			end
		endcase
		return r;
	endfunction

	// random slot that is in use; returns 0 when none is
	function automatic bit pick_busy_slot(output logic [9:0] s);
		int start;
		start = $urandom_range(0, NSLOT - 1);
		for (int k = 0; k < NSLOT; k++) begin
			s = 10'(start + k);
			if (busy[s])
				return 1'b1;
		end
		return 1'b0;
	endfunction

	// mostly well-formed commands aimed at live slots, the rest noise
	function automatic req_beat_t rand_slot_op(input int rel_pct);
		req_beat_t b;
		logic [9:0] s;
		bit hit;
		int r;
		b.op = 2'($urandom);
		b.parent_pid = $urandom;
		b.lookup_id = $urandom;
		b.check_perm = 1'($urandom);
		b.slot_in = 10'($urandom);
		hit = pick_busy_slot(s);
		r = $urandom_range(0, 99);
		if (r < rel_pct) begin
			b.op = OP_RELEASE;
			if (hit && $urandom_range(0, 6) != 0)
				b.slot_in = s;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				b.op = OP_ALLOC;
				// parent is often the current process so that permission checks pass
				r = $urandom_range(0, 4);
				if (r < 2 && cur_ok && written[cur_slot])
					b.parent_pid = slot_pid[cur_slot];
				else if (r == 2 && hit)
					b.parent_pid = slot_pid[s];
				else if (r == 3)
					b.parent_pid = '0;
			end else if (r < 80) begin
				b.op = OP_LOOKUP;
				r = $urandom_range(0, 9);
				if (r < 6 && hit)
					b.lookup_id = slot_pid[s];
				else if (r == 6)
					b.lookup_id = '0;
				else if (r == 7 && hit)
					b.lookup_id = slot_pid[s] ^ (32'd1 << $urandom_range(11, 31));
				else if (r == 8 && written[b.slot_in])
					b.lookup_id = slot_pid[b.slot_in];	// possibly a stale id
				// a current slot that never held a process has no id to read
				if (cur_ok && !written[cur_slot]) begin
					b.check_perm = 1'b0;
					if (b.lookup_id == '0)
						b.lookup_id[31] = 1'b1;
				end
			end else begin
				b.op = OP_SET_CUR;
				if (hit && $urandom_range(0, 9) < 7)
					b.slot_in = s;
			end
		end
		return b;
	endfunction

	function automatic step_t step(input op_t op, input logic [31:0] par, input logic [31:0] lid,
			input bit chk, input logic [9:0] sl, input bit fx, input logic [1:0] st,
			input logic [9:0] so, input bit sv, input logic [31:0] id);
		step_t t;
		t.beat = '{op, par, lid, chk, sl};
		t.fixed = fx;
		t.want = '{st, so, sv, id};
		return t;
	endfunction

	// one request beat: hold until taken, log what it owes, then maybe pause the burst
	task automatic send_beat(input req_beat_t b, input bit fixed, input rsp_beat_t want);
		rsp_beat_t got;
		req <= b;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		got = run_slot_op(b);
		rsp_due.push_back(fixed ? want : got);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 10);
		end
	endtask

	// response side: compare each taken beat with the oldest owed one
	always @(posedge clk) begin : rsp_check
		rsp_beat_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due.size() == 0) begin
				$error("response beat with nothing outstanding");
				mismatches++;
			end else begin
				want = rsp_due.pop_front();
				if (rsp.status !== want.status) begin
					$error("field status expected %0d actual %0d", want.status, rsp.status);
					mismatches++;
				end
				if (rsp.slot_out !== want.slot_out) begin
					$error("field slot_out expected %0d actual %0d", want.slot_out,
						rsp.slot_out);
					mismatches++;
				end
				if (rsp.slot_valid !== want.slot_valid) begin
					$error("field slot_valid expected %0d actual %0d", want.slot_valid,
						rsp.slot_valid);
					mismatches++;
				end
				if (rsp.id_out !== want.id_out) begin
					$error("field id_out expected %0h actual %0h", want.id_out, rsp.id_out);
					mismatches++;
				end
			end
		end
	end

	// receiver stall: stretches of no stall, coin flips, and heavy back-pressure
	initial begin : rsp_stall_gen
		int mode;
		rsp_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(20, 200)) begin
				@(negedge clk);
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= 1'($urandom_range(0, 1));
					default: rsp_stall <= ($urandom_range(0, 9) < 8);
				endcase
			end
		end
	end

	initial begin : stimulus
		step_t t;
		int n;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;

		for (int i = 0; i < NSLOT; i++) begin
			free_stk[i] = 10'(NSLOT - 1 - i);
			busy[i] = 1'b0;
			written[i] = 1'b0;
		end
		free_cnt = NSLOT;
		id_ctr = '0;
		cur_slot = '0;
		cur_ok = 1'b0;

		// directed walk: empty table, parent/child permission, current slot cleared on release
		steps.push_back(step(OP_LOOKUP, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));
		steps.push_back(step(OP_RELEASE, 0, 0, 0, 5, 1, ST_BAD, 0, 0, 0));
		steps.push_back(step(OP_LOOKUP, 0, 32'h800, 1, 0, 1, ST_BAD, 0, 0, 0));
		steps.push_back(step(OP_ALLOC, 0, 0, 0, 0, 1, ST_OK, 0, 1, 32'h800));
		steps.push_back(step(OP_ALLOC, 32'h800, 0, 0, 0, 1, ST_OK, 1, 1, 32'h1001));
		steps.push_back(step(OP_ALLOC, 32'hFFFF_FFFF, 0, 0, 10'h3FF, 1, ST_OK, 2, 1, 32'h1802));
		steps.push_back(step(OP_SET_CUR, 0, 0, 0, 0, 1, ST_OK, 0, 1, 0));
		steps.push_back(step(OP_LOOKUP, 0, 0, 0, 0, 1, ST_OK, 0, 1, 32'h800));
		steps.push_back(step(OP_LOOKUP, 0, 32'h1001, 1, 0, 1, ST_OK, 1, 1, 32'h1001));
		steps.push_back(step(OP_LOOKUP, 0, 32'h1802, 1, 0, 1, ST_BAD, 0, 0, 0));
		steps.push_back(step(OP_LOOKUP, 0, 32'h1802, 0, 0, 1, ST_OK, 2, 1, 32'h1802));
		steps.push_back(step(OP_LOOKUP, 0, 32'h800, 1, 0, 1, ST_OK, 0, 1, 32'h800));
		steps.push_back(step(OP_LOOKUP, 0, 32'h1002, 0, 0, 1, ST_BAD, 0, 0, 0));
		steps.push_back(step(OP_RELEASE, 0, 0, 0, 0, 1, ST_OK, 0, 1, 32'h800));
		steps.push_back(step(OP_LOOKUP, 0, 0, 0, 0, 1, ST_OK, 0, 0, 0));
		steps.push_back(step(OP_LOOKUP, 0, 32'h1001, 1, 0, 1, ST_BAD, 0, 0, 0));
		steps.push_back(step(OP_SET_CUR, 0, 0, 0, 10'h3FF, 1, ST_OK, 10'h3FF, 1, 0));
		steps.push_back(step(OP_RELEASE, 0, 0, 0, 10'h3FF, 1, ST_BAD, 0, 0, 0));
		steps.push_back(step(OP_SET_CUR, 0, 0, 0, 1, 1, ST_OK, 1, 1, 0));
		steps.push_back(step(OP_ALLOC, 32'h1001, 0, 0, 0, 1, ST_OK, 0, 1, 32'h2000));
		steps.push_back(step(OP_LOOKUP, 0, 32'h800, 0, 0, 1, ST_BAD, 0, 0, 0));
		steps.push_back(step(OP_LOOKUP, 0, 32'h2000, 1, 0, 1, ST_OK, 0, 1, 32'h2000));
		steps.push_back(step(OP_RELEASE, 0, 0, 0, 1, 1, ST_OK, 1, 1, 32'h1001));
		steps.push_back(step(OP_ALLOC, $urandom, 0, 0, 0, 0, ST_OK, 0, 0, 0));
		steps.push_back(step(OP_LOOKUP, 0, $urandom, 0, 0, 0, ST_OK, 0, 0, 0));

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (steps[i])
			send_beat(steps[i].beat, steps[i].fixed, steps[i].want);

		n = 0;
		while (n < N_RANDOM) begin
			if (n == 150) begin
				// fill every slot, then ask for more than there is
				while (free_cnt > 0) begin
					t.beat = rand_slot_op(0);
					t.beat.op = OP_ALLOC;
					send_beat(t.beat, 1'b0, '0);
					n++;
				end
				repeat (4) begin
					t.beat = rand_slot_op(0);
					t.beat.op = OP_ALLOC;
					send_beat(t.beat, 1'b0, '0);
					n++;
				end
				// free about a quarter through release-heavy traffic
				while (free_cnt < NSLOT / 4) begin
					send_beat(rand_slot_op(80), 1'b0, '0);
					n++;
				end
			end
			send_beat(rand_slot_op(20), 1'b0, '0);
			n++;
		end
		req_valid <= 1'b0;

		while (rsp_due.size() != 0)
			@(posedge clk);
		// wait on to catch any stray response beat
		repeat (12) @(posedge clk);
		if (mismatches == 0 && rsp_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("status: fail");
		$finish;
	end

endmodule
